@@ rtl/core/cscan_pkg.sv @@
`default_nettype none

package cscan_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int TRACK_BITS   = 16;
	localparam int TOTAL_BITS   = 22;
	localparam int KIND_BITS    = 2;
	localparam int CFG_IDX_W    = 2;

	// store index and fill-count widths
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

	// move kinds
	localparam logic [KIND_BITS-1:0] KIND_SERVE = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_EDGE  = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_WRAP  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_UP    = 2'd2;

	typedef struct packed {
		logic [TRACK_BITS-1:0] request_track;
		logic                  batch_last;
	} req_word_t;

	typedef struct packed {
		logic [TRACK_BITS-1:0] head_track;
		logic [TRACK_BITS-1:0] move_distance;
		logic [KIND_BITS-1:0]  move_kind;
		logic [TOTAL_BITS-1:0] total_seek;
		logic                  dropped_flag;
		logic                  sequence_last;
	} res_word_t;

	// shared compare/subtract unit result
	typedef struct packed {
		logic                  lt;
		logic                  eq;
		logic [TRACK_BITS-1:0] absd;
	} alu_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS,
		ST_PLACE,
		ST_PREP,
		ST_SRCH,
		ST_SETA,
		ST_RD,
		ST_SV,
		ST_EDGE,
		ST_JUMP
	} seq_state_t;

endpackage

`default_nettype wire

@@ rtl/core/cscan_alu.sv @@
`default_nettype none

// one subtractor: a < b, a == b, |a - b|
module cscan_alu
	import cscan_pkg::*;
(
	input  wire logic [TRACK_BITS-1:0] a,
	input  wire logic [TRACK_BITS-1:0] b,
	output alu_res_t                   res
);

	logic [TRACK_BITS:0] diff;

	assign diff = {1'b0, a} - {1'b0, b};

	always_comb begin
		res.lt   = diff[TRACK_BITS];
		res.eq   = (diff == '0);
		res.absd = diff[TRACK_BITS] ? (~diff[TRACK_BITS-1:0] + 1'b1) : diff[TRACK_BITS-1:0];
	end

endmodule

`default_nettype wire

@@ rtl/core/cscan_disk_scheduler.sv @@
`default_nettype none

// Channel  Dir  Handshake            Word
// req      in   req_valid/req_stall  req_word_t: request_track, batch_last
// res      out  res_valid/res_stall  res_word_t: head, distance, kind, total, flags
// cfg      in   cfg_we               cfg_index selects register, cfg_data
//
// Load: stored entries are compared from the top; each above the new track is
//   moved up until one stops the walk, then the track is placed; a dropped word skips the store.
// Schedule: a search for the split, a read and a subtract per served request,
//   steps for the pass end, edge and wrap; one shared subtractor.
// Reset is asynchronous; it empties the batch and loads register defaults.
// req_stall is high while busy; res_stall freezes only the step loading res.
module cscan_disk_scheduler
	import cscan_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_word_t             req,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_word_t                  res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [TRACK_BITS-1:0] cfg_data
);

	// configuration
	logic [TRACK_BITS-1:0] start_head_q;
	logic [TRACK_BITS-1:0] disk_end_q;
	logic                  scan_up_q;

	// sequencer and batch state
	seq_state_t            state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  overflow_q, overflow_d;
	logic [CNT_W-1:0]      k_q, k_d;        // insertion slot
	logic [CNT_W-1:0]      j_q, j_d;        // search pointer
	logic [CNT_W-1:0]      i_q, i_d;        // split point
	logic [CNT_W-1:0]      addr_q, addr_d;  // emission read pointer
	logic [CNT_W-1:0]      rem_q, rem_d;    // serves left in this pass
	logic                  phase_b_q, phase_b_d;
	logic [TRACK_BITS-1:0] head_q, head_d;
	logic [TOTAL_BITS-1:0] total_q, total_d;
	logic [TRACK_BITS-1:0] track_q;
	logic                  last_q;

	// request store
	logic [TRACK_BITS-1:0] mem_q [MAX_REQUESTS];
	logic [TRACK_BITS-1:0] rdata_q;
	logic                  rd_en, wr_en;
	logic [IDX_W-1:0]      raddr, waddr;
	logic [TRACK_BITS-1:0] wdata;

	// shared unit
	logic [TRACK_BITS-1:0] alu_a, alu_b;
	alu_res_t              alu_res;

	// output register
	logic                  res_valid_q;
	res_word_t             res_q;
	res_word_t             out_d;
	logic                  out_load;
	logic                  out_free;

	logic                  req_accept;
	logic [CNT_W-1:0]      count_m1, k_m1, k_m2, j_inc, b_rem, addr_step;
	logic [TOTAL_BITS-1:0] total_sum;

	cscan_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	assign count_m1  = count_q - CNT_W'(1);
	assign k_m1      = k_q - CNT_W'(1);
	assign k_m2      = k_q - CNT_W'(2);
	assign j_inc     = j_q + CNT_W'(1);
	// second pass length: below split going up, above it going down
	assign b_rem     = scan_up_q ? i_q : (count_q - i_q);
	assign addr_step = scan_up_q ? (addr_q + CNT_W'(1)) : (addr_q - CNT_W'(1));
	assign total_sum = total_q + TOTAL_BITS'(alu_res.absd);

	// configuration writes; the host must write only while no batch is in flight (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q <= '0;
			disk_end_q   <= '1;
			scan_up_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_HEAD: start_head_q <= cfg_data;
				REG_DISK_END:   disk_end_q   <= cfg_data;
				REG_SCAN_UP:    scan_up_q    <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// store: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			overflow_q <= overflow_d;
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q       <= k_d;
		j_q       <= j_d;
		i_q       <= i_d;
		addr_q    <= addr_d;
		rem_q     <= rem_d;
		phase_b_q <= phase_b_d;
		head_q    <= head_d;
		total_q   <= total_d;
		if (req_accept) begin
			track_q <= req.request_track;
			last_q  <= req.batch_last;
		end
		if (out_load) begin
			res_q <= out_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		overflow_d = overflow_q;
		k_d        = k_q;
		j_d        = j_q;
		i_d        = i_q;
		addr_d     = addr_q;
		rem_d      = rem_q;
		phase_b_d  = phase_b_q;
		head_d     = head_q;
		total_d    = total_q;
		rd_en      = 1'b0;
		raddr      = '0;
		wr_en      = 1'b0;
		waddr      = k_q[IDX_W-1:0];
		wdata      = rdata_q;
		alu_a      = rdata_q;
		alu_b      = head_q;
		out_load   = 1'b0;
		out_d      = '{
			head_track:    rdata_q,
			move_distance: alu_res.absd,
			move_kind:     KIND_SERVE,
			total_seek:    total_sum,
			dropped_flag:  overflow_q,
			sequence_last: 1'b0
		};

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (count_q == CNT_W'(MAX_REQUESTS)) begin
						// store full: drop, still schedule if last
						overflow_d = 1'b1;
						state_d    = req.batch_last ? ST_PREP : ST_IDLE;
					end else if (count_q == '0) begin
						k_d     = '0;
						state_d = ST_PLACE;
					end else begin
						k_d     = count_q;
						rd_en   = 1'b1;
						raddr   = count_m1[IDX_W-1:0];
						state_d = ST_INS;
					end
				end
			end

			ST_INS: begin
				// rdata_q holds entry k-1; move it up while it is above the new track
				alu_a = track_q;
				alu_b = rdata_q;
				if (alu_res.lt) begin
					wr_en = 1'b1;
					k_d   = k_m1;
					if (k_q == CNT_W'(1)) begin
						state_d = ST_PLACE;
					end else begin
						rd_en = 1'b1;
						raddr = k_m2[IDX_W-1:0];
					end
				end else begin
					state_d = ST_PLACE;
				end
			end

			ST_PLACE: begin
				wr_en   = 1'b1;
				wdata   = track_q;
				count_d = count_q + CNT_W'(1);
				state_d = last_q ? ST_PREP : ST_IDLE;
			end

			ST_PREP: begin
				rd_en   = 1'b1;
				raddr   = '0;
				j_d     = '0;
				state_d = ST_SRCH;
			end

			ST_SRCH: begin
				// up: count tracks below head; down: count tracks at or below head
				if (scan_up_q) begin
					alu_a = rdata_q;
					alu_b = start_head_q;
				end else begin
					alu_a = start_head_q;
					alu_b = rdata_q;
				end
				if (alu_res.lt == scan_up_q) begin
					if (j_inc == count_q) begin
						i_d     = count_q;
						state_d = ST_SETA;
					end else begin
						j_d   = j_inc;
						rd_en = 1'b1;
						raddr = j_inc[IDX_W-1:0];
					end
				end else begin
					i_d     = j_q;
					state_d = ST_SETA;
				end
			end

			ST_SETA: begin
				phase_b_d = 1'b0;
				head_d    = start_head_q;
				total_d   = '0;
				if (scan_up_q) begin
					addr_d = i_q;
					rem_d  = count_q - i_q;
				end else begin
					addr_d = i_q - CNT_W'(1);
					rem_d  = i_q;
				end
				state_d = ST_RD;
			end

			ST_RD: begin
				if (rem_q == '0) begin
					if (phase_b_q) begin
						count_d    = '0;
						overflow_d = 1'b0;
						state_d    = ST_IDLE;
					end else begin
						state_d = ST_EDGE;
					end
				end else begin
					rd_en   = 1'b1;
					raddr   = addr_q[IDX_W-1:0];
					state_d = ST_SV;
				end
			end

			ST_SV: begin
				if (out_free) begin
					out_load            = 1'b1;
					out_d.sequence_last = phase_b_q && (rem_q == CNT_W'(1));
					head_d              = rdata_q;
					total_d             = total_sum;
					addr_d              = addr_step;
					rem_d               = rem_q - CNT_W'(1);
					if (out_d.sequence_last) begin
						count_d    = '0;
						overflow_d = 1'b0;
						state_d    = ST_IDLE;
					end else begin
						state_d = ST_RD;
					end
				end
			end

			ST_EDGE: begin
				alu_a = scan_up_q ? disk_end_q : '0;
				alu_b = head_q;
				if (alu_res.eq) begin
					// already at the edge
					state_d = ST_JUMP;
				end else if (out_free) begin
					out_load         = 1'b1;
					out_d.head_track = alu_a;
					out_d.move_kind  = KIND_EDGE;
					head_d           = alu_a;
					total_d          = total_sum;
					state_d          = ST_JUMP;
				end
			end

			ST_JUMP: begin
				// wrap costs disk_end in either direction
				alu_a = disk_end_q;
				alu_b = '0;
				if (out_free) begin
					out_load            = 1'b1;
					out_d.head_track    = scan_up_q ? '0 : disk_end_q;
					out_d.move_kind     = KIND_WRAP;
					out_d.sequence_last = (b_rem == '0);
					head_d              = out_d.head_track;
					total_d             = total_sum;
					if (b_rem == '0) begin
						count_d    = '0;
						overflow_d = 1'b0;
						state_d    = ST_IDLE;
					end else begin
						phase_b_d = 1'b1;
						addr_d    = scan_up_q ? '0 : count_m1;
						rem_d     = b_rem;
						state_d   = ST_RD;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REQUESTS))
		else $error("request count above capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten while held");

	a_serve_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SV) |-> (rem_q != '0))
		else $error("serve step with empty pass");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_d.sequence_last) |=> (count_q == '0 && !overflow_q
			&& state_q == ST_IDLE))
		else $error("batch not cleared after final word");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SV || state_q == ST_INS) |-> req_stall)
		else $error("request taken while sequencer busy");
`endif

endmodule

`default_nettype wire
